>>> hdl/swre_pkg.sv
`default_nettype none

package swre_pkg;

	// Width of positions, strides and window IDs.
	localparam int unsigned WORD_W = 32;

	// Most window IDs sent out for one input transfer.
	localparam int unsigned MAX_IDS = 64;

	// Width of the count of remaining results in one run (0 .. MAX_IDS-1).
	localparam int unsigned LEFT_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

	// Width of the divider step counter.
	localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STRIDE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_SIZE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOTAL   = 2'd3;

	// Status of the shared divider after a pass.
	typedef struct packed {
		logic              done;
		logic              rem_nz;
		logic [WORD_W-1:0] quot;
	} div_res_t;

	// Command that starts a run of window IDs.
	typedef struct packed {
		logic [WORD_W-1:0] base_id;
		logic [LEFT_W-1:0] last_k;
		logic              cut;
	} emit_cmd_t;

	// Status of the ID sequencer.
	typedef struct packed {
		logic active;
		logic last;
	} emit_stat_t;

endpackage

`default_nettype wire

>>> hdl/swre_div.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle; the done flag is registered and rises
// with the last quotient bit.
module swre_div import swre_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [WORD_W-1:0] dividend,
	input  wire logic [WORD_W-1:0] divisor,
	output div_res_t               res
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    rem_q;
	logic [WORD_W-1:0]    dq_q;
	logic [WORD_W-1:0]    dvs_q;
	logic [WORD_W:0]      trial;
	logic [WORD_W+1:0]    diff;
	logic                 fits;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {rem_q, dq_q[WORD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign fits  = ~diff[WORD_W+1];

	// Control of the pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(WORD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and the dividend shifting into the quotient.
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
			dq_q  <= {dq_q[WORD_W-2:0], fits};
		end
	end

	assign res.done   = done_q;
	assign res.rem_nz = |rem_q;
	assign res.quot   = dq_q;

endmodule

`default_nettype wire

>>> hdl/swre_emit.sv
`default_nettype none

// Sends one window ID per cycle, counting up from the first ID, last_k + 1 IDs in all.
module swre_emit import swre_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire emit_cmd_t         cmd,
	output emit_stat_t             stat,
	output logic                   result_valid,
	output logic [WORD_W-1:0]      window_index,
	output logic                   last_of_run,
	output logic                   truncated
);

	logic              act_q;
	logic [WORD_W-1:0] idx_q;
	logic [LEFT_W-1:0] left_q;
	logic              cut_q;
	logic              at_last;

	assign at_last = (left_q == '0);

	// Run control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (load) begin
			act_q <= 1'b1;
		end else if (act_q && at_last) begin
			act_q <= 1'b0;
		end
	end

	// Current ID and the number of results still to go after it.
	always_ff @(posedge clk) begin
		if (load) begin
			idx_q  <= cmd.base_id;
			left_q <= cmd.last_k;
			cut_q  <= cmd.cut;
		end else if (act_q) begin
			idx_q  <= idx_q + WORD_W'(1);
			left_q <= left_q - LEFT_W'(1);
		end
	end

	assign result_valid = act_q;
	assign window_index = idx_q;
	assign last_of_run  = act_q & at_last;
	assign truncated    = act_q & at_last & cut_q;

	assign stat.active = act_q;
	assign stat.last   = act_q & at_last;

endmodule

`default_nettype wire

>>> hdl/stride_window_range_enumerator_top.sv
// Channel   | Signals                                         | Transfer
// ----------+-------------------------------------------------+-------------------------------
// input     | start, busy, range_low_start, range_high_start  | start high while busy is low
// result    | result_valid, window_index, last_of_run,        | every cycle result_valid is high
//           | truncated                                       |
// config    | cfg_we, cfg_index, cfg_data                     | every cycle cfg_we is high
//
// An input with n results runs through CLIP1 and CLIP2 to clip the range, CHECK, two passes
// of the shared bit-serial divider (DIVLO, DIVHI), FIN1 and FIN2 to check and clip the IDs,
// then n results on consecutive cycles (n at most 64).
// An input that gives no result drops back to idle from CLIP1, CHECK or FIN1.
// Reset clears all control state; configuration returns to stride 1, size 1, rest 0.
// The receiver cannot stall; results stream out back to back.
`default_nettype none

module stride_window_range_enumerator_top import swre_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [WORD_W-1:0]    range_low_start,
	input  wire logic [WORD_W-1:0]    range_high_start,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data,
	output logic                      result_valid,
	output logic [WORD_W-1:0]         window_index,
	output logic                      last_of_run,
	output logic                      truncated
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CLIP1 = 10'b0000000010,
		S_CLIP2 = 10'b0000000100,
		S_CHECK = 10'b0000001000,
		S_DIVLO = 10'b0000010000,
		S_DIVHI = 10'b0000100000,
		S_FIN1  = 10'b0001000000,
		S_FIN2  = 10'b0010000000,
		S_EMIT  = 10'b0100000000,
		S_SPARE = 10'b1000000000
	} state_t;

	state_t            state_q;
	logic [WORD_W-1:0] stride_q;
	logic [WORD_W-1:0] wsize_q;
	logic [WORD_W-1:0] refsize_q;
	logic [WORD_W-1:0] total_q;
	logic [WORD_W-1:0] lo_q;
	logic [WORD_W-1:0] hi_q;
	logic [WORD_W-1:0] max_q;
	logic [WORD_W-1:0] first_q;
	logic [WORD_W-1:0] last_q;
	logic [WORD_W:0]   span;
	logic [WORD_W-1:0] id_diff;
	logic              id_cut;
	logic              div_go;
	logic [WORD_W-1:0] div_dividend;
	div_res_t          div_res;
	logic              emit_load;
	emit_cmd_t         emit_cmd;
	emit_stat_t        emit_stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q  <= WORD_W'(1);
			wsize_q   <= WORD_W'(1);
			refsize_q <= '0;
			total_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_STRIDE:  stride_q  <= cfg_data;
				REG_WINDOW_SIZE:    wsize_q   <= cfg_data;
				REG_REFERENCE_SIZE: refsize_q <= cfg_data;
				REG_WINDOW_TOTAL:   total_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Last legal window start, with a borrow when the reference is too short.
	assign span = {1'b0, refsize_q} - {1'b0, wsize_q};

	// Width of the ID run and whether it exceeds the cap.
	assign id_diff = last_q - first_q;
	assign id_cut  = (id_diff >= WORD_W'(MAX_IDS));

	// The divider starts on the low end after the range check, then on the high end.
	assign div_go       = ((state_q == S_CHECK) && (lo_q <= hi_q))
		|| ((state_q == S_DIVLO) && div_res.done);
	assign div_dividend = (state_q == S_CHECK) ? lo_q : hi_q;

	assign emit_load        = (state_q == S_FIN2);
	assign emit_cmd.base_id = first_q;
	assign emit_cmd.last_k  = id_cut ? LEFT_W'(MAX_IDS - 1) : id_diff[LEFT_W-1:0];
	assign emit_cmd.cut     = id_cut;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (start) state_q <= S_CLIP1;
				S_CLIP1: begin
					if ((stride_q == '0) || span[WORD_W]) state_q <= S_IDLE;
					else state_q <= S_CLIP2;
				end
				S_CLIP2: state_q <= S_CHECK;
				S_CHECK: begin
					if (lo_q > hi_q) state_q <= S_IDLE;
					else state_q <= S_DIVLO;
				end
				S_DIVLO: if (div_res.done) state_q <= S_DIVHI;
				S_DIVHI: if (div_res.done) state_q <= S_FIN1;
				S_FIN1: begin
					if ((first_q > last_q) || (first_q >= total_q)) state_q <= S_IDLE;
					else state_q <= S_FIN2;
				end
				S_FIN2:  state_q <= S_EMIT;
				S_EMIT:  if (emit_stat.last) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Range ends and window IDs.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					lo_q <= range_low_start;
					hi_q <= range_high_start;
				end
			end
			S_CLIP1: max_q <= span[WORD_W-1:0];
			S_CLIP2: begin
				if (lo_q > max_q) lo_q <= max_q;
				if (hi_q > max_q) hi_q <= max_q;
			end
			// Rounding the low end up is a quotient plus one when a remainder is left.
			S_DIVLO: begin
				if (div_res.done) first_q <= div_res.quot + WORD_W'(div_res.rem_nz);
			end
			S_DIVHI: if (div_res.done) last_q <= div_res.quot;
			S_FIN1:  if (last_q >= total_q) last_q <= total_q - WORD_W'(1);
			default: ;
		endcase
	end

	swre_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (stride_q),
		.res      (div_res)
	);

	swre_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (emit_load),
		.cmd          (emit_cmd),
		.stat         (emit_stat),
		.result_valid (result_valid),
		.window_index (window_index),
		.last_of_run  (last_of_run),
		.truncated    (truncated)
	);

	assign busy = (state_q != S_IDLE) || emit_stat.active;

endmodule

`default_nettype wire

>>> hdl/swre_chk.sv
`default_nettype none

// Port-level checks on the enumerator.
module swre_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic result_valid,
	input wire logic last_of_run,
	input wire logic truncated
);

	// Results appear only while an input is being worked on.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside a busy period");

	// An accepted input transfer makes the block busy.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("input transfer did not make the block busy");

	// A run of results has no gaps.
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_of_run) |=> result_valid)
		else $error("gap inside a run of results");

	// The cut flag rides only on the last result.
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && truncated) |-> last_of_run)
		else $error("truncated without last_of_run");

	// A new run cannot follow directly after the last result.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_run) |=> !result_valid)
		else $error("result directly after the last of a run");

endmodule

bind stride_window_range_enumerator_top swre_chk u_swre_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.last_of_run  (last_of_run),
	.truncated    (truncated)
);

`default_nettype wire
